// File: sv/dhr_pkg.sv
// Shared types and constants for the heartbeat rate unit.
`default_nettype none
package dhr_pkg;

	localparam int SAMPLE_BITS_DEFAULT = 18;
	localparam int ELAPSED_BITS        = 10;
	localparam int THRESH_BITS         = 16;
	localparam int FRAC_BITS           = 8;
	localparam int CLOCK_BITS          = 32;
	localparam int RATE_BITS           = 16;
	localparam int QUEUE_DEPTH         = 2;
	localparam int OUT_FIELD_BITS      = 3 + RATE_BITS;
	localparam int OUT_TDATA_W         = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam logic [RATE_BITS-1:0] MS_PER_MINUTE = RATE_BITS'(60000);
	localparam logic signed [THRESH_BITS-1:0] DIP_THRESHOLD_RESET = -THRESH_BITS'(90);

	// One classified sample, handed from the front end to the rate engine.
	typedef struct packed {
		logic                 dip;
		logic                 onset;
		logic                 report;
		logic                 zero_quot;
		logic [RATE_BITS-1:0] divisor;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} bk_stat_t;

endpackage
`default_nettype wire

// File: sv/derivative_dip_heartbeat_rate_unit.sv
// Top level of the slope-threshold heartbeat rate unit.
// Usage:
// Each input item on the s_t* channel carries one infrared sample and the
// milliseconds since the previous sample. Every item produces exactly one
// result item on the m_t* channel: the dip flag, the beat onset flag, and,
// when a beat follows an earlier beat at a later clock value, a rate report
// with the mean of the current and previous beats per minute.
// The front end classifies an item in the cycle it is accepted and pushes it
// into a two-entry queue. The rate engine divides 60000 by the beat interval
// one quotient bit per cycle. A reporting item passes from the queue through
// the divide steps (skipped when the interval is so long that the quotient
// is zero) and a finish step to the output register; any other item goes
// straight from the queue to the output register. Sustained throughput is one
// item per cycle for non-reporting items while m_tready stays high; the engine takes no new item while a division runs.
// When the result receiver stalls, the output register holds its item and
// the queue absorbs up to two more before s_tready drops.
// The threshold is written over cfg_valid/cfg_ready/cfg_data, which is always
// ready; write it only while the unit is idle.
// Reset clears all beat history and the clock and restores the threshold to -90.
`default_nettype none
module derivative_dip_heartbeat_rate_unit import dhr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
	localparam int IN_TDATA_W = ((SAMPLE_BITS + ELAPSED_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// ir_sample, elapsed_ms, zero padding
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// dip_level, beat_onset, rate_valid, heart_rate, zero padding
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [THRESH_BITS-1:0] cfg_data
);

	logic     push;
	cmd_t     push_cmd;
	cmd_t     head;
	q_stat_t  q_stat;
	bk_stat_t bk_stat;

	// The front end classifies each sample and keeps all beat timing state.
	dhr_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_full    (q_stat.full),
		.push      (push),
		.cmd       (push_cmd)
	);

	// The queue lets samples keep arriving while a division is in progress.
	dhr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (bk_stat.pop),
		.head     (head),
		.stat     (q_stat)
	);

	// The rate engine owns the previous rate and the output register.
	dhr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head),
		.cmd_valid (!q_stat.empty),
		.stat      (bk_stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// The queue cannot look full and empty at once.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// The engine only takes a command while idle and only from a nonempty queue.
	a_pop_legal: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> (!bk_stat.busy && !q_stat.empty))
		else $error("command taken while busy or from an empty queue");

	// A rate report only comes with a beat onset, which only comes with a dip.
	a_report_onset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((!m_tdata[2] || m_tdata[1]) && (!m_tdata[1] || m_tdata[0])))
		else $error("rate report without onset or onset without dip");

	// Without a report the heart rate field reads zero.
	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[2]) |-> (m_tdata[3 +: RATE_BITS] == '0))
		else $error("heart rate nonzero without a report");

endmodule
`default_nettype wire

// File: sv/dhr_front.sv
// Front end: takes samples, detects dips and beat onsets, keeps the beat clock.
`default_nettype none
module dhr_front import dhr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
	localparam int IN_TDATA_W = ((SAMPLE_BITS + ELAPSED_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [THRESH_BITS-1:0] cfg_data,
	input  wire logic                   q_full,
	output logic                        push,
	output cmd_t                        cmd
);

	localparam int LHS_W  = SAMPLE_BITS + 1 + FRAC_BITS;
	localparam int PROD_W = THRESH_BITS + ELAPSED_BITS + 1;
	localparam int CMP_W  = (LHS_W > PROD_W) ? LHS_W : PROD_W;

	logic signed [THRESH_BITS-1:0] thr_q;
	logic [SAMPLE_BITS-1:0]        prev_sample_q;
	logic                          prev_dip_q;
	logic [CLOCK_BITS-1:0]         clock_q;
	logic [CLOCK_BITS-1:0]         last_beat_q;
	logic                          beat_seen_q;

	logic [SAMPLE_BITS-1:0]   sample;
	logic [ELAPSED_BITS-1:0]  elapsed;
	logic signed [SAMPLE_BITS:0] diff_s;
	logic signed [PROD_W-1:0] prod_s;
	logic signed [CMP_W-1:0]  lhs_w;
	logic signed [CMP_W-1:0]  rhs_w;
	logic                     dip;
	logic                     onset;
	logic [CLOCK_BITS-1:0]    clock_next;
	logic [CLOCK_BITS-1:0]    interval;

	assign sample  = s_tdata[SAMPLE_BITS-1:0];
	assign elapsed = s_tdata[SAMPLE_BITS +: ELAPSED_BITS];

	// Slope test without division: diff * 256 < threshold * elapsed.
	assign diff_s = $signed({1'b0, sample}) - $signed({1'b0, prev_sample_q});
	assign prod_s = thr_q * $signed({1'b0, elapsed});
	assign lhs_w  = CMP_W'(diff_s) <<< FRAC_BITS;
	assign rhs_w  = CMP_W'(prod_s);
	assign dip    = lhs_w < rhs_w;
	assign onset  = dip && !prev_dip_q;

	assign clock_next = clock_q + CLOCK_BITS'(elapsed);
	assign interval   = clock_next - last_beat_q;

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;
	assign push      = s_tvalid && s_tready;

	always_comb begin
		cmd.dip       = dip;
		cmd.onset     = onset;
		cmd.report    = onset && beat_seen_q && (interval != '0);
		// Intervals of 65536 ms or more do not fit the divisor; their quotient is zero.
		cmd.zero_quot = (interval[CLOCK_BITS-1:RATE_BITS] != '0);
		cmd.divisor   = interval[RATE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= DIP_THRESHOLD_RESET;
			prev_sample_q <= '0;
			prev_dip_q    <= 1'b0;
			clock_q       <= '0;
			last_beat_q   <= '0;
			beat_seen_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= $signed(cfg_data);
			end
			if (push) begin
				prev_sample_q <= sample;
				prev_dip_q    <= dip;
				clock_q       <= clock_next;
				if (onset) begin
					last_beat_q <= clock_next;
					beat_seen_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/dhr_fifo.sv
// Short command queue between the front end and the rate engine.
`default_nettype none
module dhr_fifo import dhr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output q_stat_t   stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/dhr_back.sv
// Rate engine: serial divide of 60000 by the beat interval and the output register.
`default_nettype none
module dhr_back import dhr_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	input  wire logic                   cmd_valid,
	output bk_stat_t                    stat,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam int STEP_W = $clog2(RATE_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]             state_q;
	logic                   dip_q;
	logic                   onset_q;
	logic [RATE_BITS-1:0]   div_q;
	logic [RATE_BITS-1:0]   num_q;
	logic [RATE_BITS-1:0]   rem_q;
	logic [RATE_BITS-1:0]   quo_q;
	logic [STEP_W-1:0]      step_q;
	logic [RATE_BITS-1:0]   prev_rate_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                 out_free;
	logic                 pop;
	logic                 out_load;
	logic [RATE_BITS:0]   rem_sh;
	logic                 ge;
	logic [RATE_BITS:0]   rate_sum;

	assign out_free = !out_valid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && cmd_valid && out_free;
	// A new result enters the output register on either of these.
	assign out_load = (pop && !cmd.report) || ((state_q == ST_FIN) && out_free);

	// One quotient bit per cycle, restoring form.
	assign rem_sh   = {rem_q, num_q[RATE_BITS-1]};
	assign ge       = rem_sh >= {1'b0, div_q};
	assign rate_sum = {1'b0, quo_q} + {1'b0, prev_rate_q};

	assign stat.pop  = pop;
	assign stat.busy = (state_q != ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					dip_q   <= cmd.dip;
					onset_q <= cmd.onset;
					div_q   <= cmd.divisor;
					num_q   <= MS_PER_MINUTE;
					rem_q   <= '0;
					quo_q   <= '0;
					if (!cmd.report) begin
						out_data_q <= OUT_TDATA_W'({RATE_BITS'(0), 1'b0, cmd.onset, cmd.dip});
					end
				end
			end
			ST_DIV: begin
				rem_q <= ge ? RATE_BITS'(rem_sh - {1'b0, div_q}) : rem_sh[RATE_BITS-1:0];
				quo_q <= {quo_q[RATE_BITS-2:0], ge};
				num_q <= {num_q[RATE_BITS-2:0], 1'b0};
			end
			ST_FIN: begin
				if (out_free) begin
					out_data_q <= OUT_TDATA_W'({rate_sum[RATE_BITS:1], 1'b1, onset_q, dip_q});
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			prev_rate_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (pop && cmd.report) begin
						if (cmd.zero_quot) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(RATE_BITS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						prev_rate_q <= quo_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the slope-threshold heartbeat rate unit.
`timescale 1ns / 100ps
module tb_top;
	import dhr_pkg::*;

	// The sample width follows the default build of the unit.
	localparam int SAMPLE_W   = SAMPLE_BITS_DEFAULT;
	localparam int IN_TDATA_W = ((SAMPLE_W + ELAPSED_BITS + 7) / 8) * 8;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	// A reporting sample passes the serial divider on its way to the output.
	localparam int SETTLE_CYCLES = 25;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PHASES        = 5;
	localparam int PHASE_ITEMS   = 110;

	// One result item as the unit reports it.
	typedef struct packed {
		logic                 dip;
		logic                 onset;
		logic                 valid;
		logic [RATE_BITS-1:0] rate;
	} beat_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_THRESH} row_kind_t;

	// One line of the directed script. Rows with typed set carry an expected
	// result that is written out by hand; all other rows use the predictor.
	typedef struct packed {
		row_kind_t               kind;
		logic [SAMPLE_W-1:0]     sample;
		logic [ELAPSED_BITS-1:0] elapsed;
		logic [THRESH_BITS-1:0]  thresh;
		logic                    typed;
		beat_result_t            want;
	} directed_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// ir_sample, elapsed_ms, zero padding
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// dip_level, beat_onset, rate_valid, heart_rate, zero padding
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [THRESH_BITS-1:0] cfg_data;

	derivative_dip_heartbeat_rate_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the detector state, kept in step with accepted items.
	logic signed [THRESH_BITS-1:0] dip_threshold = DIP_THRESHOLD_RESET;
	logic [SAMPLE_W-1:0]           last_sample   = '0;
	logic                          last_dip      = 1'b0;
	logic [CLOCK_BITS-1:0]         run_clock_ms  = '0;
	logic [CLOCK_BITS-1:0]         last_beat_ms  = '0;
	logic                          beat_seen     = 1'b0;
	logic [RATE_BITS-1:0]          last_bpm      = '0;

	beat_result_t pending_results[$];
	int mismatches    = 0;
	int samples_sent  = 0;
	int onsets_seen   = 0;
	int rates_seen    = 0;
	int thresh_writes = 0;
	int burst_left    = 0;

	// Waveform generator state for the random part.
	int  wave_level   = 131072;
	bit  wave_falling = 1'b0;
	int  wave_steps   = 0;

	// Classifies one sample, advances the beat history and returns the result
	// the unit should report for it. The dip test is kept division-free:
	// diff * 256 against threshold * elapsed, both in 64-bit signed range.
	function automatic beat_result_t track_heartbeat(input logic [SAMPLE_W-1:0] sample,
			input logic [ELAPSED_BITS-1:0] elapsed);
		beat_result_t          res;
		longint                diff;
		longint                thr;
		longint                span;
		logic [CLOCK_BITS-1:0] interval;
		logic [CLOCK_BITS-1:0] bpm;
		logic [RATE_BITS:0]    rate_sum;
		diff = longint'(sample) - longint'(last_sample);
		thr  = dip_threshold;
		span = longint'(elapsed);
		res.dip   = (diff * 256 < thr * span);
		res.onset = res.dip && !last_dip;
		res.valid = 1'b0;
		res.rate  = '0;
		last_sample  = sample;
		run_clock_ms = run_clock_ms + CLOCK_BITS'(elapsed);
		if (res.onset) begin
			interval = run_clock_ms - last_beat_ms;
			if (beat_seen && interval != 0) begin
				bpm = 32'd60000 / interval;
				if (bpm > 32'd65535)
					bpm = 32'd65535;
				rate_sum  = {1'b0, bpm[RATE_BITS-1:0]} + {1'b0, last_bpm};
				res.rate  = rate_sum[RATE_BITS:1];
				res.valid = 1'b1;
				last_bpm  = bpm[RATE_BITS-1:0];
			end
			last_beat_ms = run_clock_ms;
			beat_seen    = 1'b1;
		end
		last_dip = res.dip;
		return res;
	endfunction

	// Offers one sample with the sender's burst and gap pattern. Called and
	// returning at a falling edge.
	task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
			input logic [ELAPSED_BITS-1:0] elapsed, input logic typed,
			input beat_result_t typed_res);
		beat_result_t res;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
			                                          : $urandom_range(1, 20);
		end
		s_tdata  <= IN_TDATA_W'({elapsed, sample});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		res = track_heartbeat(sample, elapsed);
		pending_results.push_back(typed ? typed_res : res);
		samples_sent++;
		onsets_seen += res.onset;
		rates_seen  += res.valid;
		burst_left--;
		@(negedge clk);
	endtask

	// Lets every outstanding result come back, then waits out the settle time so
	// the rate engine is surely idle. Ends at a falling edge.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		for (int k = 0; k < DRAIN_LIMIT && pending_results.size() != 0; k++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Threshold writes only happen with the unit drained.
	task automatic write_threshold(input logic [THRESH_BITS-1:0] value);
		drain_results();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		dip_threshold = value;
		thresh_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Produces the next random sample. Most samples follow a sawtooth-like
	// pulse so that dips, onsets and rate reports keep coming; the rest are
	// raw noise over the full field ranges.
	task automatic next_wave_sample(output logic [SAMPLE_W-1:0] sample,
			output logic [ELAPSED_BITS-1:0] elapsed);
		int step;
		if ($urandom_range(0, 99) < 12) begin
			sample  = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			elapsed = ELAPSED_BITS'($urandom_range(0, 1023));
		end else begin
			if (wave_steps == 0) begin
				wave_falling = !wave_falling;
				wave_steps   = wave_falling ? $urandom_range(1, 4) : $urandom_range(2, 10);
			end
			wave_steps--;
			step = $urandom_range(0, 4000);
			wave_level = wave_falling ? wave_level - step : wave_level + step / 2;
			if (wave_level < 0)
				wave_level = 0;
			if (wave_level > SAMPLE_MAX)
				wave_level = SAMPLE_MAX;
			sample = SAMPLE_W'(wave_level);
			// Now and then a zero or a long gap between samples.
			if ($urandom_range(0, 15) == 0)
				elapsed = '0;
			else if ($urandom_range(0, 19) == 0)
				elapsed = ELAPSED_BITS'($urandom_range(41, 1023));
			else
				elapsed = ELAPSED_BITS'($urandom_range(1, 40));
		end
	endtask

	// The receiver switches between stall styles: always ready, coin flip,
	// mostly stalled, and long alternating stall and ready stretches.
	int stall_mode = 0;
	int mode_left  = 0;
	int hold_left  = 0;
	bit hold_ready = 1'b1;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(50, 200);
		end
		mode_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (hold_left == 0) begin
					hold_ready = !hold_ready;
					hold_left  = hold_ready ? $urandom_range(1, 10) : $urandom_range(1, 30);
				end
				hold_left--;
				m_tready <= hold_ready;
			end
		endcase
	end

	// Result checker: every accepted result is matched to the oldest prediction.
	always @(posedge clk) begin
		beat_result_t got;
		beat_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.dip   = m_tdata[0];
			got.onset = m_tdata[1];
			got.valid = m_tdata[2];
			got.rate  = m_tdata[3 +: RATE_BITS];
			if (pending_results.size() == 0) begin
				$error("result item arrived with no sample outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.dip !== want.dip) begin
					$error("dip_level: expected %0d, actual %0d", want.dip, got.dip);
					mismatches++;
				end
				if (got.onset !== want.onset) begin
					$error("beat_onset: expected %0d, actual %0d", want.onset, got.onset);
					mismatches++;
				end
				if (got.valid !== want.valid) begin
					$error("rate_valid: expected %0d, actual %0d", want.valid, got.valid);
					mismatches++;
				end
				if (got.rate !== want.rate) begin
					$error("heart_rate: expected %0d, actual %0d", want.rate, got.rate);
					mismatches++;
				end
			end
		end
	end

	// Directed script. The first rows follow straight from reset: a flat
	// start, a full-scale rise, a first beat that reports nothing, samples
	// with zero elapsed time, a second beat at the very same clock value, and
	// a beat one millisecond later that gives the fastest possible rate.
	// Later rows take the threshold to its extremes and to zero.
	localparam int SCRIPT_ROWS = 28;
	directed_row_t script [0:SCRIPT_ROWS-1];

	initial begin
		script = '{
			'{ROW_SAMPLE, 18'd0,      10'd1,    16'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd0}},
			'{ROW_SAMPLE, 18'd262143, 10'd1023, 16'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd0}},
			'{ROW_SAMPLE, 18'd0,      10'd1023, 16'd0, 1'b1, '{1'b1, 1'b1, 1'b0, 16'd0}},
			'{ROW_SAMPLE, 18'd0,      10'd0,    16'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd0}},
			'{ROW_SAMPLE, 18'd100,    10'd0,    16'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd0}},
			'{ROW_SAMPLE, 18'd50,     10'd0,    16'd0, 1'b1, '{1'b1, 1'b1, 1'b0, 16'd0}},
			'{ROW_SAMPLE, 18'd50,     10'd0,    16'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd0}},
			'{ROW_SAMPLE, 18'd0,      10'd1,    16'd0, 1'b1, '{1'b1, 1'b1, 1'b1, 16'd30000}},
			'{ROW_SAMPLE, 18'd0,      10'd1,    16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd262143, 10'd0,    16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd0,      10'd1,    16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd0,      10'd1023, 16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd0,      10'd1023, 16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd262143, 10'd1023, 16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd0,      10'd1023, 16'd0, 1'b0, '0},
			'{ROW_THRESH, 18'd0,      10'd0,    16'h7FFF, 1'b0, '0},
			'{ROW_SAMPLE, 18'd1000,   10'd1,    16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd262143, 10'd1,    16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd262143, 10'd1023, 16'd0, 1'b0, '0},
			'{ROW_THRESH, 18'd0,      10'd0,    16'h8000, 1'b0, '0},
			'{ROW_SAMPLE, 18'd0,      10'd1,    16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd262143, 10'd1023, 16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd262000, 10'd1023, 16'd0, 1'b0, '0},
			'{ROW_THRESH, 18'd0,      10'd0,    16'h0000, 1'b0, '0},
			'{ROW_SAMPLE, 18'd261000, 10'd5,    16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd261000, 10'd5,    16'd0, 1'b0, '0},
			'{ROW_SAMPLE, 18'd0,      10'd5,    16'd0, 1'b0, '0},
			'{ROW_THRESH, 18'd0,      10'd0,    DIP_THRESHOLD_RESET, 1'b0, '0}
		};
	end

	// Main stimulus sequence.
	initial begin
		logic [SAMPLE_W-1:0]     sample;
		logic [ELAPSED_BITS-1:0] elapsed;
		logic [THRESH_BITS-1:0]  phase_thresh;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_THRESH)
				write_threshold(script[i].thresh);
			else
				send_sample(script[i].sample, script[i].elapsed, script[i].typed,
				            script[i].want);
		end

		// Random phases, each under its own threshold. Every phase starts
		// with the unit drained, which also gives the sender a long pause.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: phase_thresh = DIP_THRESHOLD_RESET;
				1: phase_thresh = -THRESH_BITS'($urandom_range(1, 1500));
				2: phase_thresh = THRESH_BITS'($urandom_range(0, 65535));
				3: phase_thresh = -THRESH_BITS'($urandom_range(1, 400));
				default: phase_thresh = THRESH_BITS'($urandom_range(0, 200));
			endcase
			write_threshold(phase_thresh);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				next_wave_sample(sample, elapsed);
				send_sample(sample, elapsed, 1'b0, '0);
			end
		end

		drain_results();
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end

		$display("Run covered %0d samples with %0d beat onsets and %0d rate reports,",
		         samples_sent, onsets_seen, rates_seen);
		$display("under %0d threshold writes including both extremes and zero.",
		         thresh_writes);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
sv/dhr_pkg.sv
sv/dhr_front.sv
sv/dhr_fifo.sv
sv/dhr_back.sv
sv/derivative_dip_heartbeat_rate_unit.sv
test/tb_top.sv
